// File: sv/cct_pkg.sv
// shared constants, types and state codes for the contour circle test
`default_nettype none

package cct_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned TolBits   = 12;
  localparam int unsigned TolReset  = 20;

  localparam int unsigned AddrBits  = $clog2(MaxPoints);
  localparam int unsigned CountBits = AddrBits + 1;
  localparam int unsigned RadBits   = CoordBits - 1;
  localparam int unsigned PointBits = 2 * CoordBits;
  // radius plus tolerance plus one always fits here
  localparam int unsigned HiBits    = ((CoordBits > TolBits) ? CoordBits : TolBits) + 1;
  localparam int unsigned SqBits    = 2 * HiBits;
  localparam int unsigned SumBits   = 2 * CoordBits + 1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [SqBits-1:0]    sq_t;

  typedef struct packed {
    logic busy;
    logic miss;
  } chk_status_t;

  typedef enum logic [4:0] {
    ST_LOAD    = 5'b00001,
    ST_ROOTS   = 5'b00010,
    ST_SQUARES = 5'b00100,
    ST_CHECK   = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// File: sv/cct_point_store.sv
// point memory: one write port, one registered read port
`default_nettype none

module cct_point_store (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [cct_pkg::AddrBits-1:0]  wr_addr_i,
  input  wire logic [cct_pkg::PointBits-1:0] wr_data_i,
  input  wire logic                          rd_en_i,
  input  wire logic [cct_pkg::AddrBits-1:0]  rd_addr_i,
  output logic      [cct_pkg::PointBits-1:0] rd_data_o
);

  logic [cct_pkg::PointBits-1:0] mem [cct_pkg::MaxPoints];
  logic [cct_pkg::PointBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sv/cct_dist_check.sv
// distance check pipeline: squared distance against the allowed ring bounds
`default_nettype none

module cct_dist_check (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pt_valid_i,
  input  wire logic [cct_pkg::PointBits-1:0] pt_data_i,
  input  wire cct_pkg::coord_t               center_x_i,
  input  wire cct_pkg::coord_t               center_y_i,
  input  wire cct_pkg::sq_t                  lo_sq_i,
  input  wire cct_pkg::sq_t                  hi_sq_i,
  output cct_pkg::chk_status_t               status_o
);

  cct_pkg::coord_t px, py;
  cct_pkg::coord_t dx_d, dy_d, dx_q, dy_q;
  logic            a_valid_q, b_valid_q;
  logic [2*cct_pkg::CoordBits-1:0] dxsq_q, dysq_q;
  logic [cct_pkg::SumBits-1:0]     sum;
  cct_pkg::sq_t                    sum_w;

  assign px = pt_data_i[cct_pkg::CoordBits-1:0];
  assign py = pt_data_i[cct_pkg::PointBits-1:cct_pkg::CoordBits];

  always_comb begin
    dx_d = (px >= center_x_i) ? (px - center_x_i) : (center_x_i - px);
    dy_d = (py >= center_y_i) ? (py - center_y_i) : (center_y_i - py);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pt_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dxsq_q <= dx_q * dx_q;
    dysq_q <= dy_q * dy_q;
  end

  // floor(sqrt(s)) lies in [r-t, r+t] exactly when lo <= s < hi
  assign sum   = {1'b0, dxsq_q} + {1'b0, dysq_q};
  assign sum_w = cct_pkg::sq_t'(sum);

  assign status_o.busy = a_valid_q | b_valid_q;
  assign status_o.miss = b_valid_q & ((sum_w < lo_sq_i) | (sum_w >= hi_sq_i));

endmodule

`default_nettype wire

// File: sv/contour_circle_test_core.sv
// contour circle test: point loading, ring bounds, distance pass and result register
//
// Input channel: one contour point per transfer (point_x_i, point_y_i, last_point_i),
// valid/ready handshake. Points load at one per cycle while in_ready_o is high; each
// is written to the point memory (up to MaxPoints entries) and folded into the
// bounding box. After the transfer that carries last_point_i, in_ready_o drops while
// the block forms radius, centre and the squared ring bounds (ST_ROOTS, then
// ST_SQUARES), then walks the stored points through the memory read port and a
// pipelined distance check, one point per cycle. A contour that overflowed skips
// the walk and goes straight to its result.
// Output channel: one result per contour, held in an output register until the
// receiver takes it. A new contour may load while that result waits; a finished
// check waits for the register to free before the block reopens for input.
// cfg_we_i/cfg_wdata_i write the tolerance; write only while the block is idle.
// Reset (rst_ni low, asynchronous) empties the contour, sets tolerance to its
// default and drops out_valid_o; memory contents are not cleared.
`default_nettype none

module contour_circle_test_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cct_pkg::TolBits-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cct_pkg::CoordBits-1:0] point_x_i,
  input  wire logic [cct_pkg::CoordBits-1:0] point_y_i,
  input  wire logic                          last_point_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               is_circle_o,
  output logic      [cct_pkg::CoordBits-1:0] center_x_o,
  output logic      [cct_pkg::CoordBits-1:0] center_y_o,
  output logic      [cct_pkg::RadBits-1:0]   circle_radius_o,
  output logic      [cct_pkg::CoordBits-1:0] box_min_x_o,
  output logic      [cct_pkg::CoordBits-1:0] box_max_x_o,
  output logic      [cct_pkg::CoordBits-1:0] box_min_y_o,
  output logic      [cct_pkg::CoordBits-1:0] box_max_y_o,
  output logic                               too_many_points_o
);

  localparam logic [cct_pkg::CountBits-1:0] CountFull =
    cct_pkg::CountBits'(cct_pkg::MaxPoints);

  cct_pkg::state_e state_q, state_d;

  logic [cct_pkg::TolBits-1:0]   tol_q;
  logic [cct_pkg::CountBits-1:0] count_q, idx_q;
  cct_pkg::coord_t               min_x_q, max_x_q, min_y_q, max_y_q, anchor_y_q;
  logic                          ovf_q, seen_q, fail_q, rd_valid_q;

  logic [cct_pkg::RadBits-1:0]   rad_q, rad_d;
  cct_pkg::coord_t               cx_q;
  logic [cct_pkg::HiBits-1:0]    rad_w, tol_w, lo_root_q, hi_root_q;
  cct_pkg::sq_t                  lo_sq_q, hi_sq_q, lo_sq_d, hi_sq_d;
  cct_pkg::coord_t               width_x;

  logic                          out_valid_q, is_circle_q, too_many_q;
  cct_pkg::coord_t               o_cx_q, o_cy_q, o_min_x_q, o_max_x_q, o_min_y_q, o_max_y_q;
  logic [cct_pkg::RadBits-1:0]   o_rad_q;

  logic                          in_xfer, wr_en, rd_en, emit, out_free;
  logic [cct_pkg::PointBits-1:0] rd_data;
  cct_pkg::chk_status_t          chk;

  assign in_ready_o = (state_q == cct_pkg::ST_LOAD);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign wr_en      = in_xfer & (count_q != CountFull);
  assign rd_en      = (state_q == cct_pkg::ST_CHECK) & (idx_q != count_q);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign emit       = (state_q == cct_pkg::ST_EMIT) & out_free;

  cct_point_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[cct_pkg::AddrBits-1:0]),
    .wr_data_i ({point_y_i, point_x_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[cct_pkg::AddrBits-1:0]),
    .rd_data_o (rd_data)
  );

  cct_dist_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_valid_i (rd_valid_q),
    .pt_data_i  (rd_data),
    .center_x_i (cx_q),
    .center_y_i (anchor_y_q),
    .lo_sq_i    (lo_sq_q),
    .hi_sq_i    (hi_sq_q),
    .status_o   (chk)
  );

  // ring bounds
  assign width_x = max_x_q - min_x_q;
  assign rad_d   = width_x[cct_pkg::CoordBits-1:1];
  assign rad_w   = cct_pkg::HiBits'(rad_d);
  assign tol_w   = cct_pkg::HiBits'(tol_q);
  assign lo_sq_d = lo_root_q * lo_root_q;
  assign hi_sq_d = hi_root_q * hi_root_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cct_pkg::ST_LOAD: begin
        if (in_xfer && last_point_i) begin
          state_d = cct_pkg::ST_ROOTS;
        end
      end
      cct_pkg::ST_ROOTS:   state_d = cct_pkg::ST_SQUARES;
      cct_pkg::ST_SQUARES: state_d = ovf_q ? cct_pkg::ST_EMIT : cct_pkg::ST_CHECK;
      cct_pkg::ST_CHECK: begin
        if (!rd_en && !rd_valid_q && !chk.busy) begin
          state_d = cct_pkg::ST_EMIT;
        end
      end
      cct_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = cct_pkg::ST_LOAD;
        end
      end
      default: state_d = cct_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cct_pkg::ST_LOAD;
      tol_q       <= cct_pkg::TolBits'(cct_pkg::TolReset);
      count_q     <= '0;
      min_x_q     <= '1;
      max_x_q     <= '0;
      min_y_q     <= '1;
      max_y_q     <= '0;
      anchor_y_q  <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= 1'b0;
      fail_q      <= 1'b0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        seen_q <= 1'b1;
        if (wr_en) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
        // the first point always claims the leftmost slot
        if (!seen_q || point_x_i < min_x_q) begin
          min_x_q    <= point_x_i;
          anchor_y_q <= point_y_i;
        end
        if (point_x_i > max_x_q) max_x_q <= point_x_i;
        if (point_y_i < min_y_q) min_y_q <= point_y_i;
        if (point_y_i > max_y_q) max_y_q <= point_y_i;
      end
      if (state_q == cct_pkg::ST_SQUARES) begin
        fail_q <= ovf_q;
        idx_q  <= '0;
      end
      if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (chk.miss) begin
        fail_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        count_q     <= '0;
        min_x_q     <= '1;
        max_x_q     <= '0;
        min_y_q     <= '1;
        max_y_q     <= '0;
        anchor_y_q  <= '0;
        ovf_q       <= 1'b0;
        seen_q      <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cct_pkg::ST_ROOTS) begin
      rad_q <= rad_d;
      cx_q  <= min_x_q + cct_pkg::CoordBits'(rad_d);
    end
    if (state_q == cct_pkg::ST_SQUARES) begin
      lo_sq_q <= lo_sq_d;
      hi_sq_q <= hi_sq_d;
    end
    if (emit) begin
      is_circle_q <= ~fail_q;
      too_many_q  <= ovf_q;
      o_cx_q      <= cx_q;
      o_cy_q      <= anchor_y_q;
      o_rad_q     <= rad_q;
      o_min_x_q   <= min_x_q;
      o_max_x_q   <= max_x_q;
      o_min_y_q   <= min_y_q;
      o_max_y_q   <= max_y_q;
    end
  end

  // ring roots: r - t clipped at zero, and r + t + 1 as the open upper bound
  always_ff @(posedge clk_i) begin
    if (state_q == cct_pkg::ST_ROOTS) begin
      lo_root_q <= (rad_w > tol_w) ? (rad_w - tol_w) : '0;
      hi_root_q <= rad_w + tol_w + 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign is_circle_o       = is_circle_q;
  assign center_x_o        = o_cx_q;
  assign center_y_o        = o_cy_q;
  assign circle_radius_o   = o_rad_q;
  assign box_min_x_o       = o_min_x_q;
  assign box_max_x_o       = o_max_x_q;
  assign box_min_y_o       = o_min_y_q;
  assign box_max_y_o       = o_max_y_q;
  assign too_many_points_o = too_many_q;

  a_overflow_not_circle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_many_points_o |-> !is_circle_o)
    else $error("overflowed contour reported as circle");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> idx_q < count_q)
    else $error("distance pass read beyond stored points");

  a_count_held_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cct_pkg::ST_CHECK |=> count_q == $past(count_q))
    else $error("point count moved during distance pass");

endmodule

`default_nettype wire

// File: dv/tb.sv
// testbench for the contour circle test core: random and directed contours against a predictor
`timescale 1ns / 1ps

module tb;
  import cct_pkg::*;

  localparam int CoordMax     = (1 << CoordBits) - 1;
  localparam int SettleCycles = 16;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } ring_point_t;

  typedef struct packed {
    logic               is_circle;
    coord_t             center_x;
    coord_t             center_y;
    logic [RadBits-1:0] radius;
    coord_t             min_x;
    coord_t             max_x;
    coord_t             min_y;
    coord_t             max_y;
    logic               overflow;
  } verdict_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [TolBits-1:0] cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  coord_t             point_x_i    = '0;
  coord_t             point_y_i    = '0;
  logic               last_point_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic               is_circle_o;
  coord_t             center_x_o;
  coord_t             center_y_o;
  logic [RadBits-1:0] circle_radius_o;
  coord_t             box_min_x_o;
  coord_t             box_max_x_o;
  coord_t             box_min_y_o;
  coord_t             box_max_y_o;
  logic               too_many_points_o;

  // predictor state
  ring_point_t        ring_store [MaxPoints];
  int unsigned        stored_n;
  coord_t             lo_x, hi_x, lo_y, hi_y, anchor_y;
  bit                 spilled, started;
  logic [TolBits-1:0] tolerance = TolBits'(TolReset);

  verdict_t    expected_verdicts [$];
  ring_point_t contour_q [$];
  int          errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  contour_circle_test_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .last_point_i      (last_point_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_circle_o       (is_circle_o),
    .center_x_o        (center_x_o),
    .center_y_o        (center_y_o),
    .circle_radius_o   (circle_radius_o),
    .box_min_x_o       (box_min_x_o),
    .box_max_x_o       (box_max_x_o),
    .box_min_y_o       (box_min_y_o),
    .box_max_y_o       (box_max_y_o),
    .too_many_points_o (too_many_points_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int floor_root(longint unsigned v);
    longint unsigned root, trial;
    int b;
    root = 0;
    for (b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return int'(root);
  endfunction

  function automatic void clear_contour();
    stored_n = 0;
    lo_x     = '1;
    hi_x     = '0;
    lo_y     = '1;
    hi_y     = '0;
    anchor_y = '0;
    spilled  = 1'b0;
    started  = 1'b0;
  endfunction

  // fold one accepted point into the contour; the last point yields a verdict
  function automatic void fold_contour_point(coord_t x, coord_t y, logic last);
    verdict_t    v;
    int          radius, cx, dx, dy, ring_dist;
    int unsigned i;
    bit          round;
    if (stored_n < MaxPoints) begin
      ring_store[stored_n] = '{x: x, y: y};
      stored_n++;
    end else begin
      spilled = 1'b1;
    end
    if (!started || x < lo_x) begin
      lo_x     = x;
      anchor_y = y;
    end
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;
    started = 1'b1;
    if (last) begin
      radius = (int'(hi_x) - int'(lo_x)) / 2;
      cx     = int'(lo_x) + radius;
      round  = !spilled;
      for (i = 0; i < stored_n; i++) begin
        dx        = int'(ring_store[i].x) - cx;
        dy        = int'(ring_store[i].y) - int'(anchor_y);
        ring_dist = floor_root(longint'(dx * dx + dy * dy));
        if (((radius > ring_dist) ? radius - ring_dist : ring_dist - radius) > int'(tolerance))
          round = 1'b0;
      end
      v.is_circle = round;
      v.center_x  = cx[CoordBits-1:0];
      v.center_y  = anchor_y;
      v.radius    = radius[RadBits-1:0];
      v.min_x     = lo_x;
      v.max_x     = hi_x;
      v.min_y     = lo_y;
      v.max_y     = hi_y;
      v.overflow  = spilled;
      expected_verdicts.push_back(v);
      clear_contour();
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got centre %0d,%0d",
                 $time, center_x_o, center_y_o);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("is_circle", want.is_circle, is_circle_o);
        check_field("center_x", want.center_x, center_x_o);
        check_field("center_y", want.center_y, center_y_o);
        check_field("circle_radius", want.radius, circle_radius_o);
        check_field("box_min_x", want.min_x, box_min_x_o);
        check_field("box_max_x", want.max_x, box_max_x_o);
        check_field("box_min_y", want.min_y, box_min_y_o);
        check_field("box_max_y", want.max_y, box_max_y_o);
        check_field("too_many_points", want.overflow, too_many_points_o);
      end
    end
  end

  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    fold_contour_point(x, y, last);
  endtask

  task automatic send_contour();
    int unsigned i;
    for (i = 0; i < contour_q.size(); i++)
      send_point(contour_q[i].x, contour_q[i].y, i == contour_q.size() - 1);
  endtask

  // stop sending and wait until every verdict is out and the block has gone quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [TolBits-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tolerance = value;
  endtask

  function automatic ring_point_t clamp_point(int x, int y);
    ring_point_t p;
    p.x = (x < 0) ? '0 : (x > CoordMax) ? '1 : x[CoordBits-1:0];
    p.y = (y < 0) ? '0 : (y > CoordMax) ? '1 : y[CoordBits-1:0];
    return p;
  endfunction

  function automatic int jitter(int spread);
    if (spread <= 0) return 0;
    return int'($urandom_range(2 * spread, 0)) - spread;
  endfunction

  // leftmost and rightmost points pin the box in x, the rest sit on the ring (jittered by noise); all in random order
  function automatic void build_circle(int n, int r, int noise);
    int cx, cy, dx, dy, i, j;
    ring_point_t tmp;
    cx = $urandom_range(CoordMax - r, r);
    cy = $urandom_range(CoordMax - r, r);
    contour_q.delete();
    contour_q.push_back(clamp_point(cx - r, cy));
    contour_q.push_back(clamp_point(cx + r, cy));
    for (i = 2; i < n; i++) begin
      dx = $urandom_range(r, 0);
      dy = floor_root(longint'(r * r - dx * dx));
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
      contour_q.push_back(clamp_point(cx + dx + jitter(noise), cy + dy + jitter(noise)));
    end
    for (i = contour_q.size() - 1; i > 0; i--) begin
      j            = $urandom_range(i, 0);
      tmp          = contour_q[i];
      contour_q[i] = contour_q[j];
      contour_q[j] = tmp;
    end
  endfunction

  function automatic void build_scatter(int n, int cx, int cy, int spread);
    int i;
    contour_q.delete();
    for (i = 0; i < n; i++)
      contour_q.push_back(clamp_point(cx + jitter(spread), cy + jitter(spread)));
  endfunction

  function automatic logic [TolBits-1:0] random_tolerance();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return TolBits'($urandom_range(6, 0));
    if (pick < 8) return TolBits'($urandom_range(40, 7));
    return TolBits'($urandom_range(CoordMax, 0));
  endfunction

  task automatic test_directed_contours();
    // lone point at all ones still takes least x and the anchor
    contour_q.delete();
    contour_q.push_back(clamp_point(CoordMax, CoordMax));
    send_contour();
    contour_q.delete();
    contour_q.push_back(clamp_point(0, 0));
    send_contour();
    // full extent, widest radius; a later tie on x keeps the first anchor
    contour_q.delete();
    contour_q.push_back(clamp_point(CoordMax, 0));
    contour_q.push_back(clamp_point(0, CoordMax));
    contour_q.push_back(clamp_point(0, 0));
    send_contour();
    // strictly smaller x moves the anchor
    contour_q.delete();
    contour_q.push_back(clamp_point(10, 5));
    contour_q.push_back(clamp_point(20, 6));
    contour_q.push_back(clamp_point(5, 7));
    contour_q.push_back(clamp_point(5, 8));
    send_contour();
    // exact ring of radius 10
    contour_q.delete();
    contour_q.push_back(clamp_point(90, 100));
    contour_q.push_back(clamp_point(110, 100));
    contour_q.push_back(clamp_point(100, 90));
    contour_q.push_back(clamp_point(100, 110));
    contour_q.push_back(clamp_point(106, 108));
    contour_q.push_back(clamp_point(94, 92));
    send_contour();
    // tall spike far outside the radius
    contour_q.delete();
    contour_q.push_back(clamp_point(0, 0));
    contour_q.push_back(clamp_point(100, 0));
    contour_q.push_back(clamp_point(50, 2000));
    send_contour();
  endtask

  task automatic test_store_limit();
    set_tolerance(TolBits'(3));
    build_circle(MaxPoints, 1000, 0);
    send_contour();
    build_circle(MaxPoints + 1, 1500, 0);
    send_contour();
    // points past the store still widen the box
    build_circle(MaxPoints, 600, 0);
    contour_q.push_back(clamp_point(0, CoordMax));
    contour_q.push_back(clamp_point(CoordMax, 0));
    send_contour();
  endtask

  task automatic test_random_contours(input int unsigned n_items, input logic [TolBits-1:0] first_tol);
    int unsigned sent, contours, pick;
    int          n, r;
    set_tolerance(first_tol);
    sent     = 0;
    contours = 0;
    while (sent < n_items) begin
      n    = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 2);
      r    = ($urandom_range(9) == 0) ? $urandom_range(2047, 0) : $urandom_range(120, 0);
      pick = $urandom_range(99);
      if (pick < 60) begin
        build_circle(n, r, $urandom_range(3, 0));
      end else if (pick < 75) begin
        // ring with one stray point
        build_circle(n, r, 0);
        contour_q[$urandom_range(contour_q.size() - 1, 0)] =
          clamp_point($urandom_range(CoordMax, 0), $urandom_range(CoordMax, 0));
      end else if (pick < 85) begin
        build_scatter(n, $urandom_range(CoordMax, 0), $urandom_range(CoordMax, 0),
                      $urandom_range(60, 0));
      end else if (pick < 95) begin
        build_scatter(n, 2048, 2048, 2048);
      end else begin
        build_scatter(1, 2048, 2048, 2048);
      end
      send_contour();
      sent += contour_q.size();
      contours++;
      if (contours % 12 == 0 && sent < n_items) set_tolerance(random_tolerance());
    end
  endtask

  initial begin
    clear_contour();
    send_idle_pct = 36;
    recv_idle_pct = 79;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_contours();
    test_random_contours(600, '0);
    send_idle_pct = 79;
    recv_idle_pct = 36;
    test_store_limit();
    test_random_contours(600, '1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_contours(600, TolBits'(2));
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
